>>> rtl/pee_pkg.sv
// Shared types, character codes and class codes for the parenthesis expression evaluator.
package pee_pkg;

    // Default stack depth for nested parentheses.
    localparam int NEST_DEPTH_DEF = 32;

    // Number of entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Value width of the arithmetic.
    localparam int DATA_W = 32;

    // Character codes that the evaluator recognizes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;

    // Character classes produced by the front.
    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_DIGIT = 3'd1;
    localparam logic [2:0] CLS_PLUS  = 3'd2;
    localparam logic [2:0] CLS_MINUS = 3'd3;
    localparam logic [2:0] CLS_OPEN  = 3'd4;
    localparam logic [2:0] CLS_CLOSE = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DEEP     = 2'd1;
    localparam logic [1:0] STAT_UNMATCH  = 2'd2;
    localparam logic [1:0] STAT_UNCLOSED = 2'd3;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic       last;
    } item_t;

    // One saved stack frame: the outer sum and its sign.
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] sum;
    } stack_entry_t;

endpackage

>>> rtl/paren_expression_evaluator_unit.sv
// The last character passes through the queue and then sets the output register that holds the result.
// Throughput: one character per cycle; the back executes one queued character each cycle,
// with the stack top held in a register and deeper frames in a RAM with a bypass.
// A result that waits on the output register only stalls last characters behind it.
// Reset clears the sum, sign, digit register, nesting level, error and queue; the stack
// RAM is not cleared, since every frame is written before it is read.
module paren_expression_evaluator_unit
    import pee_pkg::*;
    #(
        parameter int NEST_DEPTH = NEST_DEPTH_DEF
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        s_tvalid,
        output logic        s_tready,
        input  logic [7:0]  s_tdata,   // [7:0] char_in
        input  logic        s_tlast,   // is_last
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [39:0] m_tdata    // [31:0] value, [33:32] status, [39:34] zero
    );

    item_t front_item;
    item_t queue_item;
    logic  queue_valid;
    logic  back_ready;

    // Character classification.
    pee_front u_front
        (
            .char_in (s_tdata),
            .is_last (s_tlast),
            .item    (front_item)
        );

    // Decoupling queue.
    pee_queue u_queue
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .push_valid (s_tvalid),
            .push_ready (s_tready),
            .push_item  (front_item),
            .pop_valid  (queue_valid),
            .pop_ready  (back_ready),
            .pop_item   (queue_item)
        );

    // Execution and result output.
    pee_back
        #(
            .NEST_DEPTH (NEST_DEPTH)
        )
        u_back
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (queue_valid),
            .in_ready (back_ready),
            .in_item  (queue_item),
            .m_tvalid (m_tvalid),
            .m_tready (m_tready),
            .m_tdata  (m_tdata)
        );

endmodule

>>> rtl/pee_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pee_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             wr_en,
        input  logic [AW-1:0]    wr_addr,
        input  logic [WIDTH-1:0] wr_data,
        input  logic [AW-1:0]    rd_addr,
        output logic [WIDTH-1:0] rd_data
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and read-first registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pee_front.sv
// Front of the evaluator: classifies each incoming character.
module pee_front
    import pee_pkg::*;
    (
        input  logic [7:0] char_in,
        input  logic       is_last,
        output item_t      item
    );

    // Decode the character into its class and digit value.
    always_comb
    begin
        item.last  = is_last;
        item.digit = 4'(char_in - CHAR_ZERO);
        unique case (char_in) inside
            [CHAR_ZERO:CHAR_NINE]: item.cls = CLS_DIGIT;
            CHAR_PLUS:             item.cls = CLS_PLUS;
            CHAR_MINUS:            item.cls = CLS_MINUS;
            CHAR_OPEN:             item.cls = CLS_OPEN;
            CHAR_CLOSE:            item.cls = CLS_CLOSE;
            default:               item.cls = CLS_OTHER;
        endcase
    end

endmodule

>>> rtl/pee_queue.sv
// Short queue of classified characters between the front and the back.
module pee_queue
    import pee_pkg::*;
    (
        input  logic  clk,
        input  logic  rst_n,
        input  logic  push_valid,
        output logic  push_ready,
        input  item_t push_item,
        output logic  pop_valid,
        input  logic  pop_ready,
        output item_t pop_item
    );

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/pee_back.sv
// Back of the evaluator: carries out each character against the sum, sign and stack.
module pee_back
    import pee_pkg::*;
    #(
        parameter int NEST_DEPTH = NEST_DEPTH_DEF
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        in_valid,
        output logic        in_ready,
        input  item_t       in_item,
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [39:0] m_tdata
    );

    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int SW = $bits(stack_entry_t);

    // Evaluation state.
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] sum_next;
    logic              neg_reg;
    logic              neg_next;
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;
    logic [1:0]        err_reg;
    logic [1:0]        err_next;
    stack_entry_t      top_reg;
    stack_entry_t      top_next;

    // Write-through bypass for the entry under the top.
    logic              byp_valid_reg;
    logic              byp_valid_next;
    stack_entry_t      byp_data_reg;

    // Output register.
    logic              o_valid_reg;
    logic              o_valid_next;
    logic [DATA_W-1:0] o_sum_reg;
    logic [DATA_W-1:0] o_acc_reg;
    logic              o_neg_reg;
    logic [1:0]        o_status_reg;
    logic [DATA_W-1:0] o_value;

    // Stack memory signals.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    stack_entry_t      wr_data;
    logic [AW-1:0]     rd_addr;
    logic [SW-1:0]     rd_data;
    stack_entry_t      below;

    // Per-character arithmetic.
    logic [DATA_W-1:0] term;
    logic [DATA_W-1:0] inner;
    logic [DATA_W-1:0] acc_times10;
    logic [DATA_W-1:0] closed_sum;
    logic [1:0]        err_step;
    logic              out_free;
    logic              take;
    logic              finish;

    assign out_free = !o_valid_reg || m_tready;
    assign in_ready = !in_item.last || out_free;
    assign take     = in_valid && in_ready;
    assign finish   = take && in_item.last;

    assign term        = neg_reg ? (DATA_W'(0) - acc_reg) : acc_reg;
    assign inner       = sum_reg + term;
    assign acc_times10 = {acc_reg[DATA_W-4:0], 3'b000} + {acc_reg[DATA_W-2:0], 1'b0}
                       + {{(DATA_W-4){1'b0}}, in_item.digit};
    assign closed_sum  = top_reg.neg ? (top_reg.sum - inner) : (top_reg.sum + inner);
    assign below       = byp_valid_reg ? byp_data_reg : stack_entry_t'(rd_data);

    // Execute one character and prepare the next state.
    always_comb
    begin
        acc_next   = acc_reg;
        sum_next   = sum_reg;
        neg_next   = neg_reg;
        level_next = level_reg;
        top_next   = top_reg;
        err_step   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(level_reg - LW'(1));
        wr_data    = top_reg;
        if (take)
        begin
            unique case (in_item.cls)
                CLS_DIGIT:
                begin
                    acc_next = acc_times10;
                end
                CLS_PLUS, CLS_MINUS:
                begin
                    sum_next = inner;
                    neg_next = (in_item.cls == CLS_MINUS);
                    acc_next = '0;
                end
                CLS_OPEN:
                begin
                    if (level_reg < LW'(NEST_DEPTH))
                    begin
                        // Spill the current top to memory before replacing it.
                        wr_en        = (level_reg != '0);
                        top_next.sum = sum_reg;
                        top_next.neg = neg_reg;
                        level_next   = level_reg + LW'(1);
                        sum_next     = '0;
                        neg_next     = 1'b0;
                    end
                    else if (err_reg == STAT_OK)
                    begin
                        err_step = STAT_DEEP;
                    end
                end
                CLS_CLOSE:
                begin
                    acc_next = '0;
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - LW'(1);
                        sum_next   = closed_sum;
                        top_next   = below;
                    end
                    else
                    begin
                        sum_next = inner;
                        if (err_reg == STAT_OK)
                        begin
                            err_step = STAT_UNMATCH;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        // An open parenthesis left at the end is flagged if no earlier error was flagged.
        err_next = err_step;
        if (finish && (level_next != '0) && (err_step == STAT_OK))
        begin
            err_next = STAT_UNCLOSED;
        end
    end

    // Keep the memory read pointed at the entry under the top after this cycle.
    always_comb
    begin
        if (!finish && (level_next >= LW'(2)))
        begin
            rd_addr = AW'(level_next - LW'(2));
        end
        else
        begin
            rd_addr = '0;
        end
        byp_valid_next = wr_en && (wr_addr == rd_addr);
    end

    // Output valid follows a finished expression until the transaction completes.
    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (finish)
        begin
            o_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Control and evaluation state; the last character clears the evaluation state and the bypass flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            level_reg     <= '0;
            err_reg       <= STAT_OK;
            byp_valid_reg <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            o_valid_reg   <= o_valid_next;
            byp_valid_reg <= finish ? 1'b0 : byp_valid_next;
            if (finish)
            begin
                acc_reg   <= '0;
                sum_reg   <= '0;
                neg_reg   <= 1'b0;
                level_reg <= '0;
                err_reg   <= STAT_OK;
            end
            else
            begin
                acc_reg   <= acc_next;
                sum_reg   <= sum_next;
                neg_reg   <= neg_next;
                level_reg <= level_next;
                err_reg   <= err_next;
            end
        end
    end

    // Payload registers: stack top, bypass data and the result terms.
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= wr_data;
        if (finish)
        begin
            o_sum_reg    <= sum_next;
            o_acc_reg    <= acc_next;
            o_neg_reg    <= neg_next;
            o_status_reg <= err_next;
        end
    end

    // Final fold of the pending number into the sum.
    assign o_value  = o_sum_reg + (o_neg_reg ? (DATA_W'(0) - o_acc_reg) : o_acc_reg);
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'b000000, o_status_reg, o_value};

    // Saved frames below the top of the stack.
    pee_ram
        #(
            .WIDTH (SW),
            .DEPTH (NEST_DEPTH)
        )
        u_stack
        (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr),
            .rd_data (rd_data)
        );

endmodule
